// File: rtl/stbs_pkg.sv
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int TABLE_DEPTH   = 1024;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int POS_W         = 11;
  localparam int KEY_W         = 32;
  localparam int REC_W         = 32;
  localparam int PAYLOAD_WIDTH = 32;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_RDERR    = 2'd2,
    ST_WRITE    = 2'd3
  } stat_t;

  typedef struct packed {
    stat_t                    status;
    logic [POS_W-1:0]         pos;
    logic signed [KEY_W-1:0]  key;
    logic [REC_W-1:0]         rec;
  } res_t;

endpackage

// File: rtl/stbs_if.sv
`timescale 1ns / 1ps

interface stbs_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [stbs_pkg::POS_W-1:0]         position;
  logic signed [stbs_pkg::KEY_W-1:0]  key;
  logic [stbs_pkg::REC_W-1:0]         record_data;
  logic [stbs_pkg::POS_W-1:0]         first_pos;
  logic [stbs_pkg::POS_W-1:0]         last_pos;

  modport source (
    output valid, cmd, position, key, record_data, first_pos, last_pos,
    input  ready
  );
  modport sink (
    input  valid, cmd, position, key, record_data, first_pos, last_pos,
    output ready
  );
endinterface

interface stbs_out_if;
  logic                               valid;
  logic                               ready;
  stbs_pkg::stat_t                    status;
  logic [stbs_pkg::POS_W-1:0]         found_position;
  logic signed [stbs_pkg::KEY_W-1:0]  found_key;
  logic [stbs_pkg::REC_W-1:0]         found_record;

  modport source (
    output valid, status, found_position, found_key, found_record,
    input  ready
  );
  modport sink (
    input  valid, status, found_position, found_key, found_record,
    output ready
  );
endinterface

// File: rtl/sorted_table_binary_search_top.sv
`timescale 1ns / 1ps

// Binary search over a table of signed keys with payloads, 1-based positions.
// A write item finishes in the cycle in which it is accepted. A search item issues
// its first probe in the cycle in which it is accepted, then goes on one probe
// at a time until it ends. One probe per cycle is the rate of the single-port table
// memory, whose read data is registered; the next probe address is computed
// from the compare result in the same cycle. Results go to an output register
// with one more holding stage behind it, so a new item is taken while a result
// waits. cfg_wdata (valid_count) should be written only while the block is idle.
module sorted_table_binary_search_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [stbs_pkg::POS_W-1:0] cfg_wdata,
  stbs_in_if.sink                    in_if,
  stbs_out_if.source                 out_if
);
  import stbs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CMP  = 2'b10
  } state_t;

  typedef struct packed {
    logic             empty;
    logic             err;
    logic [POS_W-1:0] mid;
  } dec_t;

  localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(TABLE_DEPTH);

  function automatic dec_t decide(input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi,
                                  input logic [POS_W-1:0] limit);
    logic [POS_W:0] sum;
    dec_t           d;
    sum     = {1'b0, lo} + {1'b0, hi};
    d.mid   = sum[POS_W:1];
    d.empty = lo > hi;
    d.err   = (d.mid == '0) || (d.mid > limit);
    return d;
  endfunction

  state_t                        state_r, state_nxt;
  logic [POS_W-1:0]              limit_r;
  logic [POS_W-1:0]              lo_r, lo_nxt;
  logic [POS_W-1:0]              hi_r, hi_nxt;
  logic [POS_W-1:0]              mid_r, mid_nxt;
  logic signed [KEY_W-1:0]       key_r, key_nxt;
  logic [KEY_W+PAYLOAD_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [KEY_W+PAYLOAD_WIDTH-1:0] rd_r;
  logic                          rd_en, wr_en;
  logic [ADDR_W-1:0]             rd_addr, wr_addr;
  logic                          in_xfer;
  logic                          fin;
  res_t                          fin_res;
  res_t                          out_r, res_r;
  logic                          out_valid_r, pend_r;
  logic                          out_free;
  dec_t                          dec_in, dec_dn, dec_up, dec_sel;
  logic                          go;
  logic signed [KEY_W-1:0]       probe_key;
  logic [PAYLOAD_WIDTH-1:0]      probe_pay;
  logic [POS_W-1:0]              mid_dec, mid_inc;

  assign in_if.ready = (state_r == S_IDLE) && !pend_r;
  assign in_xfer     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;

  assign probe_key = rd_r[KEY_W+PAYLOAD_WIDTH-1:PAYLOAD_WIDTH];
  assign probe_pay = rd_r[PAYLOAD_WIDTH-1:0];
  assign mid_dec   = mid_r - POS_W'(1);
  assign mid_inc   = mid_r + POS_W'(1);
  assign wr_addr   = ADDR_W'(in_if.position - POS_W'(1));

  always_comb begin
    dec_in    = decide(in_if.first_pos, in_if.last_pos, limit_r);
    dec_dn    = decide(lo_r, mid_dec, limit_r);
    dec_up    = decide(mid_inc, hi_r, limit_r);
    dec_sel   = dec_in;
    go        = 1'b0;
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    fin       = 1'b0;
    fin_res   = '0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_if.cmd == CMD_WRITE) begin
            // positions outside the table are dropped but still answered
            wr_en          = (in_if.position != '0) && (in_if.position <= DEPTH_POS);
            fin            = 1'b1;
            fin_res.status = ST_WRITE;
          end else begin
            lo_nxt  = in_if.first_pos;
            hi_nxt  = in_if.last_pos;
            key_nxt = in_if.key;
            dec_sel = dec_in;
            go      = 1'b1;
          end
        end
      end
      S_CMP: begin
        if (probe_key == key_r) begin
          fin            = 1'b1;
          fin_res.status = ST_FOUND;
          fin_res.pos    = mid_r;
          fin_res.key    = probe_key;
          fin_res.rec    = REC_W'(probe_pay);
          state_nxt      = S_IDLE;
        end else if (probe_key > key_r) begin
          hi_nxt  = mid_dec;
          dec_sel = dec_dn;
          go      = 1'b1;
        end else begin
          lo_nxt  = mid_inc;
          dec_sel = dec_up;
          go      = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (go) begin
      if (dec_sel.empty) begin
        fin            = 1'b1;
        fin_res.status = ST_NOTFOUND;
        state_nxt      = S_IDLE;
      end else if (dec_sel.err) begin
        fin            = 1'b1;
        fin_res.status = ST_RDERR;
        state_nxt      = S_IDLE;
      end else begin
        rd_en     = 1'b1;
        mid_nxt   = dec_sel.mid;
        state_nxt = S_CMP;
      end
    end
  end

  assign rd_addr = ADDR_W'(mid_nxt - POS_W'(1));

  // table memory, one access per cycle, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_if.key, in_if.record_data[PAYLOAD_WIDTH-1:0]};
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        limit_r <= (cfg_wdata > DEPTH_POS) ? DEPTH_POS : cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
  end

  // output register plus one holding stage for a result that finishes while blocked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (pend_r) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end
    end else if (fin) begin
      if (out_free) begin
        out_valid_r <= 1'b1;
      end else begin
        pend_r <= 1'b1;
      end
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      if (out_free) begin
        out_r <= res_r;
      end
    end else if (fin) begin
      if (out_free) begin
        out_r <= fin_res;
      end else begin
        res_r <= fin_res;
      end
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.status         = out_r.status;
  assign out_if.found_position = out_r.pos;
  assign out_if.found_key      = out_r.key;
  assign out_if.found_record   = out_r.rec;

  a_pend_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("held result without a result in the output register");

  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (mid_r != '0) && (mid_r <= limit_r))
    else $error("probe outside loaded records");

  a_mid_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (lo_r <= mid_r) && (mid_r <= hi_r))
    else $error("probe outside search window");

  a_fin_lands: assert property (@(posedge clk) disable iff (!rst_n)
    fin |=> out_valid_r)
    else $error("finished item produced no result");

  a_no_fin_while_pend: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !fin)
    else $error("second result finished while one is held");

endmodule
